/* hw/rtl/dte_pkg.sv */
// Shared types and constants for the device table engine.
`timescale 1ns / 1ps

package dte_pkg;

    localparam int DEPTH_DEF = 64;

    localparam logic [15:0] NO_VENDOR = 16'hFFFF;
    localparam logic [7:0]  SYN_BUS   = 8'hFE;

    localparam int IN_DATA_W  = 200;
    localparam int OUT_DATA_W = 192;

    typedef enum logic [2:0] {
        OP_CLEAR      = 3'd0,
        OP_INS_PROBED = 3'd1,
        OP_INS_SYNTH  = 3'd2,
        OP_FIND_LOC   = 3'd3,
        OP_FIND_IDS   = 3'd4,
        OP_FIND_CLASS = 3'd5,
        OP_REMOVE     = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_BAD_INDEX = 3'd3,
        ST_NOT_SYNTH = 3'd4,
        ST_NO_DEVICE = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0]  bus;
        logic [4:0]  slot;
        logic [2:0]  func;
        logic [15:0] vendor;
        logic [15:0] product;
        logic [7:0]  cls;
        logic [7:0]  sub;
    } t_key;

    typedef struct packed {
        logic [7:0]  bus;
        logic [4:0]  slot;
        logic [2:0]  func;
        logic [15:0] vendor;
        logic [15:0] product;
        logic [7:0]  cls;
        logic [7:0]  sub;
        logic        syn;
        logic [63:0] base;
        logic [63:0] size;
    } t_entry;

endpackage

/* hw/rtl/dte_store.sv */
// Entry memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module dte_store
    import dte_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

/* hw/rtl/dte_match.sv */
// Shared key compare unit used by the lookup scan.
`timescale 1ns / 1ps

module dte_match
    import dte_pkg::*;
(
    input  t_op    i_op,
    input  t_key   i_key,
    input  t_entry i_ent,
    output logic   o_hit
);

    always_comb begin
        unique case (i_op)
            OP_FIND_LOC: begin
                o_hit = (i_ent.bus == i_key.bus) && (i_ent.slot == i_key.slot) &&
                        (i_ent.func == i_key.func);
            end
            OP_FIND_IDS: begin
                o_hit = (i_ent.vendor == i_key.vendor) &&
                        (i_ent.product == i_key.product);
            end
            OP_FIND_CLASS: begin
                o_hit = (i_ent.cls == i_key.cls) && (i_ent.sub == i_key.sub);
            end
            default: begin
                o_hit = 1'b0;
            end
        endcase
    end

endmodule

/* hw/rtl/device_table_engine_core.sv */
// Device table engine top level: command sequencer, entry memory and compare unit.
//
// Commands enter on the s_axis channel (opcode in tuser, operands in tdata) and
// each one returns exactly one result word on the m_axis channel (status in
// tuser, index, count and entry in tdata). One command is in flight at a time;
// s_axis_tready is high only while the engine is idle with no result pending.
// Clear, insert and unused opcodes go from acceptance straight to the result state.
// Lookups scan the table in insertion order, one entry read per cycle through
// the single memory read port, and stop at the first hit. Remove reads the
// addressed entry; a synthetic one is taken out by moving every later entry
// down one place, one per cycle on the read and write ports together, and a
// probed one is refused. A refused index answers without a memory read.
// Reset empties the table at once (the count goes to zero; memory contents
// are left as they are and never read before being rewritten).
// A stalled receiver holds the result word and keeps new commands out.
`timescale 1ns / 1ps

module device_table_engine_core
    import dte_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // bus, slot_num, func_num, vendor_key, product_key, class_key, subclass_key,
    // region_base, region_size, entry_index, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic [2:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // result_index, entry_count, out_bus, out_slot, out_func, out_vendor,
    // out_product, out_synthetic, out_region_base, out_region_size, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status
    output logic [2:0]            m_axis_tuser
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int KW = (CW > 7) ? CW : 7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RM_RD,
        S_RM_CHK,
        S_SHIFT,
        S_OUT
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_ptr, n_ptr;
    logic [AW-1:0]   r_pidx, n_pidx;
    logic            r_pend, n_pend;
    t_op             r_op, n_op;
    t_key            r_key, n_key;
    t_status         r_status, n_status;
    logic [5:0]      r_ridx, n_ridx;
    t_entry          r_ent, n_ent;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    t_entry          mem_wdata;
    logic [AW-1:0]   mem_raddr;
    t_entry          mem_rdata;
    logic            hit;

    t_op             in_op;
    t_key            in_key;
    logic [63:0]     in_base;
    logic [63:0]     in_size;
    logic [5:0]      in_idx;
    logic [KW-1:0]   in_idx_k;
    logic [KW-1:0]   cnt_k;
    logic [KW-1:0]   pidx_k;
    logic [KW-1:0]   out_cnt_k;
    t_entry          new_ent;

    assign in_op    = t_op'(s_axis_tuser);
    assign in_key   = '{bus:     s_axis_tdata[7:0],
                        slot:    s_axis_tdata[12:8],
                        func:    s_axis_tdata[15:13],
                        vendor:  s_axis_tdata[31:16],
                        product: s_axis_tdata[47:32],
                        cls:     s_axis_tdata[55:48],
                        sub:     s_axis_tdata[63:56]};
    assign in_base  = s_axis_tdata[127:64];
    assign in_size  = s_axis_tdata[191:128];
    assign in_idx   = s_axis_tdata[197:192];
    assign in_idx_k = KW'(in_idx);
    assign cnt_k    = KW'(r_count);
    assign pidx_k   = KW'(r_pidx);

    always_comb begin
        new_ent.vendor  = in_key.vendor;
        new_ent.product = in_key.product;
        new_ent.cls     = in_key.cls;
        new_ent.sub     = in_key.sub;
        if (in_op == OP_INS_SYNTH) begin
            new_ent.bus  = SYN_BUS;
            new_ent.slot = cnt_k[4:0];
            new_ent.func = 3'd0;
            new_ent.syn  = 1'b1;
            new_ent.base = in_base;
            new_ent.size = in_size;
        end else begin
            new_ent.bus  = in_key.bus;
            new_ent.slot = in_key.slot;
            new_ent.func = in_key.func;
            new_ent.syn  = 1'b0;
            new_ent.base = 64'd0;
            new_ent.size = 64'd0;
        end
    end

    dte_store #(
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    dte_match u_match (
        .i_op  (r_op),
        .i_key (r_key),
        .i_ent (mem_rdata),
        .o_hit (hit)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_pidx    = r_pidx;
        n_pend    = r_pend;
        n_op      = r_op;
        n_key     = r_key;
        n_status  = r_status;
        n_ridx    = r_ridx;
        n_ent     = r_ent;
        mem_we    = 1'b0;
        mem_waddr = r_pidx;
        mem_wdata = mem_rdata;
        mem_raddr = r_ptr[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op     = in_op;
                    n_key    = in_key;
                    n_ent    = '0;
                    n_ridx   = 6'd0;
                    n_status = ST_NOT_FOUND;
                    n_state  = S_OUT;
                    unique case (in_op)
                        OP_CLEAR: begin
                            n_count  = '0;
                            n_status = ST_OK;
                        end
                        OP_INS_PROBED, OP_INS_SYNTH: begin
                            if (in_op == OP_INS_PROBED && in_key.vendor == NO_VENDOR) begin
                                n_status = ST_NO_DEVICE;
                            end else if (r_count >= CW'(TABLE_DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_count[AW-1:0];
                                mem_wdata = new_ent;
                                n_ent     = new_ent;
                                n_ridx    = cnt_k[5:0];
                                n_count   = r_count + CW'(1);
                                n_status  = ST_OK;
                            end
                        end
                        OP_FIND_LOC, OP_FIND_IDS, OP_FIND_CLASS: begin
                            n_ptr   = '0;
                            n_pend  = 1'b0;
                            n_state = S_SCAN;
                        end
                        OP_REMOVE: begin
                            n_ridx = in_idx;
                            if (in_idx_k >= cnt_k) begin
                                n_status = ST_BAD_INDEX;
                            end else begin
                                n_ptr   = in_idx_k[CW-1:0];
                                n_state = S_RM_RD;
                            end
                        end
                        default: begin
                            n_status = ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_pend && hit) begin
                    n_status = ST_OK;
                    n_ent    = mem_rdata;
                    n_ridx   = pidx_k[5:0];
                    n_pend   = 1'b0;
                    n_state  = S_OUT;
                end else if (r_ptr >= r_count) begin
                    n_pend  = 1'b0;
                    n_state = S_OUT;
                end else begin
                    n_pidx = r_ptr[AW-1:0];
                    n_pend = 1'b1;
                    n_ptr  = r_ptr + CW'(1);
                end
            end
            S_RM_RD: begin
                n_pidx  = r_ptr[AW-1:0];
                n_state = S_RM_CHK;
            end
            S_RM_CHK: begin
                n_ent = mem_rdata;
                if (!mem_rdata.syn) begin
                    n_status = ST_NOT_SYNTH;
                    n_state  = S_OUT;
                end else begin
                    n_ptr   = r_ptr + CW'(1);
                    n_pend  = 1'b0;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pidx - AW'(1);
                    mem_wdata = mem_rdata;
                end
                if (r_ptr < r_count) begin
                    n_pidx = r_ptr[AW-1:0];
                    n_pend = 1'b1;
                    n_ptr  = r_ptr + CW'(1);
                end else begin
                    n_pend   = 1'b0;
                    n_count  = r_count - CW'(1);
                    n_status = ST_OK;
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_ptr    <= n_ptr;
            r_pidx   <= n_pidx;
            r_op     <= n_op;
            r_key    <= n_key;
            r_status <= n_status;
            r_ridx   <= n_ridx;
            r_ent    <= n_ent;
        end
    end

    assign out_cnt_k     = KW'(r_count);
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {2'b00, r_ent.size, r_ent.base, r_ent.syn, r_ent.product,
                            r_ent.vendor, r_ent.func, r_ent.slot, r_ent.bus,
                            out_cnt_k[6:0], r_ridx};

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("command accepted while a result is pending");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("engine ready again right after accepting a command");

    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=> (s_axis_tready && !m_axis_tvalid))
        else $error("engine not idle after result delivered");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the device table engine: directed table, then random commands.
`timescale 1ns / 1ps

module tb_top;
    import dte_pkg::*;

    localparam int          TABLE_DEPTH = DEPTH_DEF;
    localparam logic [2:0]  OP_SPARE    = 3'd7;

    typedef struct {
        logic [2:0]  op;
        logic [7:0]  bus;
        logic [4:0]  slot;
        logic [2:0]  func;
        logic [15:0] vend;
        logic [15:0] prod;
        logic [7:0]  cls;
        logic [7:0]  sub;
        logic [63:0] base;
        logic [63:0] size;
        logic [5:0]  idx;
    } t_cmd;

    typedef struct {
        logic [2:0]  status;
        logic [5:0]  ridx;
        logic [6:0]  count;
        logic [7:0]  bus;
        logic [4:0]  slot;
        logic [2:0]  func;
        logic [15:0] vend;
        logic [15:0] prod;
        logic        syn;
        logic [63:0] base;
        logic [63:0] size;
    } t_answer;

    typedef struct {
        t_cmd    cmd;
        bit      typed;
        t_answer ans;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [2:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [2:0]            m_axis_tuser;

    t_entry  dev_table [TABLE_DEPTH];
    int      dev_count;
    t_answer answers_due [$];
    t_row    plan [$];
    int      errors;
    int      answers_seen;
    int      hold_left;
    bit      hold_done;
    bit      calm;

    device_table_engine_core #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic t_cmd mk_cmd(logic [2:0] op, logic [7:0] bus, logic [4:0] slot,
                                    logic [2:0] func, logic [15:0] vend, logic [15:0] prod,
                                    logic [7:0] cls, logic [7:0] sub, logic [63:0] base,
                                    logic [63:0] size, logic [5:0] idx);
        t_cmd c;
        c.op = op; c.bus = bus; c.slot = slot; c.func = func;
        c.vend = vend; c.prod = prod; c.cls = cls; c.sub = sub;
        c.base = base; c.size = size; c.idx = idx;
        return c;
    endfunction

    function automatic t_answer mk_ans(logic [2:0] status, logic [5:0] ridx, logic [6:0] count,
                                       logic [7:0] bus, logic [4:0] slot, logic [2:0] func,
                                       logic [15:0] vend, logic [15:0] prod, logic syn,
                                       logic [63:0] base, logic [63:0] size);
        t_answer a;
        a.status = status; a.ridx = ridx; a.count = count;
        a.bus = bus; a.slot = slot; a.func = func; a.vend = vend; a.prod = prod;
        a.syn = syn; a.base = base; a.size = size;
        return a;
    endfunction

    function automatic t_answer with_entry(t_answer a, int i);
        a.bus  = dev_table[i].bus;
        a.slot = dev_table[i].slot;
        a.func = dev_table[i].func;
        a.vend = dev_table[i].vendor;
        a.prod = dev_table[i].product;
        a.syn  = dev_table[i].syn;
        a.base = dev_table[i].base;
        a.size = dev_table[i].size;
        return a;
    endfunction

    function automatic t_answer apply_command(t_cmd c);
        t_answer a;
        int      i;
        bit      hit;
        a = mk_ans(ST_NOT_FOUND, '0, '0, '0, '0, '0, '0, '0, 1'b0, '0, '0);
        case (c.op)
            OP_CLEAR: begin
                dev_count = 0;
                a.status = ST_OK;
            end
            OP_INS_PROBED, OP_INS_SYNTH: begin
                if (c.op == OP_INS_PROBED && c.vend == NO_VENDOR) begin
                    a.status = ST_NO_DEVICE;
                end else if (dev_count >= TABLE_DEPTH) begin
                    a.status = ST_FULL;
                end else begin
                    i = dev_count;
                    dev_table[i].vendor  = c.vend;
                    dev_table[i].product = c.prod;
                    dev_table[i].cls     = c.cls;
                    dev_table[i].sub     = c.sub;
                    if (c.op == OP_INS_PROBED) begin
                        dev_table[i].bus  = c.bus;
                        dev_table[i].slot = c.slot;
                        dev_table[i].func = c.func;
                        dev_table[i].syn  = 1'b0;
                        dev_table[i].base = '0;
                        dev_table[i].size = '0;
                    end else begin
                        dev_table[i].bus  = SYN_BUS;
                        dev_table[i].slot = i[4:0];
                        dev_table[i].func = '0;
                        dev_table[i].syn  = 1'b1;
                        dev_table[i].base = c.base;
                        dev_table[i].size = c.size;
                    end
                    dev_count++;
                    a.status = ST_OK;
                    a.ridx = i[5:0];
                    a = with_entry(a, i);
                end
            end
            OP_FIND_LOC, OP_FIND_IDS, OP_FIND_CLASS: begin
                for (i = 0; i < dev_count; i++) begin
                    if (c.op == OP_FIND_LOC)
                        hit = dev_table[i].bus == c.bus && dev_table[i].slot == c.slot &&
                              dev_table[i].func == c.func;
                    else if (c.op == OP_FIND_IDS)
                        hit = dev_table[i].vendor == c.vend && dev_table[i].product == c.prod;
                    else
                        hit = dev_table[i].cls == c.cls && dev_table[i].sub == c.sub;
                    if (hit) begin
                        a.status = ST_OK;
                        a.ridx = i[5:0];
                        a = with_entry(a, i);
                        break;
                    end
                end
            end
            OP_REMOVE: begin
                a.ridx = c.idx;
                if (int'(c.idx) >= dev_count) begin
                    a.status = ST_BAD_INDEX;
                end else begin
                    a = with_entry(a, c.idx);
                    if (!dev_table[c.idx].syn) begin
                        a.status = ST_NOT_SYNTH;
                    end else begin
                        for (i = c.idx; i + 1 < dev_count; i++)
                            dev_table[i] = dev_table[i + 1];
                        dev_count--;
                        a.status = ST_OK;
                    end
                end
            end
            default: ;
        endcase
        a.count = dev_count[6:0];
        return a;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_cmd(t_cmd c);
        return {2'b00, c.idx, c.size, c.base, c.sub, c.cls, c.prod, c.vend,
                c.func, c.slot, c.bus};
    endfunction

    function automatic t_cmd rand_cmd(int mode);
        t_cmd c;
        int   r;
        int   j;
        c = mk_cmd(OP_CLEAR, $urandom_range(255), $urandom_range(31), $urandom_range(7),
                   $urandom_range(65535), $urandom_range(65535), $urandom_range(255),
                   $urandom_range(255), {$urandom, $urandom}, {$urandom, $urandom},
                   $urandom_range(63));
        if ($urandom_range(1)) begin
            c.bus = $urandom_range(3);
            c.cls = $urandom_range(3);
            c.sub = $urandom_range(3);
            c.vend = $urandom_range(3);
            c.prod = $urandom_range(3);
        end
        r = $urandom_range(99);
        if (mode == 0)
            c.op = r < 35 ? OP_INS_PROBED : r < 65 ? OP_INS_SYNTH : r < 75 ? OP_FIND_LOC :
                   r < 83 ? OP_FIND_IDS : r < 90 ? OP_FIND_CLASS : r < 97 ? OP_REMOVE :
                   r < 98 ? OP_CLEAR : OP_SPARE;
        else if (mode == 1)
            c.op = r < 20 ? OP_INS_PROBED : r < 40 ? OP_INS_SYNTH : r < 55 ? OP_FIND_LOC :
                   r < 70 ? OP_FIND_IDS : r < 85 ? OP_FIND_CLASS : r < 97 ? OP_REMOVE :
                   r < 99 ? OP_CLEAR : OP_SPARE;
        else
            c.op = r < 10 ? OP_INS_PROBED : r < 20 ? OP_INS_SYNTH : r < 30 ? OP_FIND_LOC :
                   r < 40 ? OP_FIND_IDS : r < 50 ? OP_FIND_CLASS : r < 95 ? OP_REMOVE :
                   r < 97 ? OP_CLEAR : OP_SPARE;
        if (c.op == OP_INS_PROBED && $urandom_range(19) == 0)
            c.vend = NO_VENDOR;
        if (dev_count > 0) begin
            j = $urandom_range(dev_count - 1);
            if ((c.op == OP_FIND_LOC || c.op == OP_FIND_IDS || c.op == OP_FIND_CLASS) &&
                $urandom_range(9) < 7) begin
                c.bus  = dev_table[j].bus;
                c.slot = dev_table[j].slot;
                c.func = dev_table[j].func;
                c.vend = dev_table[j].vendor;
                c.prod = dev_table[j].product;
                c.cls  = dev_table[j].cls;
                c.sub  = dev_table[j].sub;
            end
            if (c.op == OP_REMOVE && $urandom_range(3) != 0)
                c.idx = j[5:0];
        end
        return c;
    endfunction

    task automatic offer(t_cmd c, bit typed, t_answer fixed);
        t_answer guess;
        while (!calm && $urandom_range(99) < 35) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata  <= pack_cmd(c);
        s_axis_tuser  <= c.op;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        guess = apply_command(c);
        answers_due.push_back(typed ? fixed : guess);
    endtask

    task automatic drain_answers();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (answers_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            answers_seen++;
            if (answers_due.size() == 0) begin
                $error("result word with no command pending");
                errors++;
            end else begin
                want = answers_due.pop_front();
                check_field("status", want.status, m_axis_tuser);
                check_field("result_index", want.ridx, m_axis_tdata[5:0]);
                check_field("entry_count", want.count, m_axis_tdata[12:6]);
                check_field("out_bus", want.bus, m_axis_tdata[20:13]);
                check_field("out_slot", want.slot, m_axis_tdata[25:21]);
                check_field("out_func", want.func, m_axis_tdata[28:26]);
                check_field("out_vendor", want.vend, m_axis_tdata[44:29]);
                check_field("out_product", want.prod, m_axis_tdata[60:45]);
                check_field("out_synthetic", want.syn, m_axis_tdata[61]);
                check_field("out_region_base", want.base, m_axis_tdata[125:62]);
                check_field("out_region_size", want.size, m_axis_tdata[189:126]);
            end
        end
        if (!hold_done && answers_seen == 100) begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || $urandom_range(99) >= 35;
        end
    end

    initial begin
        #6_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_answer none;
        int      n;
        int      mode;
        errors        = 0;
        answers_seen  = 0;
        hold_left     = 0;
        hold_done     = 1'b0;
        calm          = 1'b0;
        dev_count     = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_CLEAR;
        m_axis_tready <= 1'b0;
        none = mk_ans(ST_OK, '0, '0, '0, '0, '0, '0, '0, 1'b0, '0, '0);

        plan.push_back('{mk_cmd(OP_FIND_LOC, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                         mk_ans(ST_NOT_FOUND, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
        plan.push_back('{mk_cmd(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                         mk_ans(ST_BAD_INDEX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
        plan.push_back('{mk_cmd(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 63), 1'b1,
                         mk_ans(ST_BAD_INDEX, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
        plan.push_back('{mk_cmd(OP_INS_PROBED, 8'hFF, 5'h1F, 3'h7, NO_VENDOR, 16'hFFFF,
                                8'hFF, 8'hFF, '1, '1, 6'h3F), 1'b1,
                         mk_ans(ST_NO_DEVICE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
        plan.push_back('{mk_cmd(OP_INS_PROBED, 8'hFF, 5'h1F, 3'h7, 16'hFFFE, 16'hFFFF,
                                8'hFF, 8'hFF, '1, '1, 6'h3F), 1'b1,
                         mk_ans(ST_OK, 0, 1, 8'hFF, 5'h1F, 3'h7, 16'hFFFE, 16'hFFFF, 0, 0, 0)});
        plan.push_back('{mk_cmd(OP_INS_PROBED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                         mk_ans(ST_OK, 1, 2, 0, 0, 0, 0, 0, 0, 0, 0)});
        plan.push_back('{mk_cmd(OP_INS_SYNTH, 8'h5A, 5'h11, 3'h3, NO_VENDOR, 0, 8'h12, 8'h34,
                                '1, '1, 0), 1'b0, none});
        plan.push_back('{mk_cmd(OP_INS_SYNTH, 0, 0, 0, 16'h1234, 16'hABCD, 8'hFF, 8'h00,
                                0, 0, 0), 1'b0, none});
        plan.push_back('{mk_cmd(OP_FIND_LOC, 8'hFF, 5'h1F, 3'h7, 0, 0, 0, 0, 0, 0, 0),
                         1'b0, none});
        plan.push_back('{mk_cmd(OP_FIND_IDS, 0, 0, 0, 16'hFFFE, 16'hFFFF, 0, 0, 0, 0, 0),
                         1'b0, none});
        plan.push_back('{mk_cmd(OP_FIND_CLASS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
        plan.push_back('{mk_cmd(OP_FIND_CLASS, 0, 0, 0, 0, 0, 8'h77, 8'h77, 0, 0, 0),
                         1'b0, none});
        plan.push_back('{mk_cmd(OP_FIND_LOC, SYN_BUS, 5'd2, 0, 0, 0, 0, 0, 0, 0, 0),
                         1'b0, none});
        plan.push_back('{mk_cmd(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
        plan.push_back('{mk_cmd(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 2), 1'b0, none});
        plan.push_back('{mk_cmd(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3), 1'b0, none});
        plan.push_back('{mk_cmd(OP_SPARE, 8'hFF, 5'h1F, 3'h7, '1, '1, '1, '1, '1, '1, '1),
                         1'b0, none});
        plan.push_back('{mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                         mk_ans(ST_OK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
        plan.push_back('{mk_cmd(OP_FIND_IDS, 0, 0, 0, 16'hFFFE, 16'hFFFF, 0, 0, 0, 0, 0),
                         1'b1, mk_ans(ST_NOT_FOUND, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
        plan.push_back('{mk_cmd(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 5), 1'b1,
                         mk_ans(ST_BAD_INDEX, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0)});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k])
            offer(plan[k].cmd, plan[k].typed, plan[k].ans);

        mode = 0;
        for (n = 0; n < 1630; n++) begin
            if (n % 150 == 0) begin
                drain_answers();
                mode = n == 0 ? 0 : $urandom_range(3);
                mode = mode < 2 ? 0 : mode - 1;
            end
            calm = n >= 700 && n < 900;
            offer(rand_cmd(mode), 1'b0, none);
        end
        calm = 1'b0;

        drain_answers();
        repeat (80) @(posedge i_clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
